[hdl/cssu_pkg.sv]
package cssu_pkg;

   localparam int TimeoutWidth = 20;
   localparam int ByteWidth    = 8;
   localparam int CountWidth   = 3;
   localparam int ElapsedWidth = 21;
   localparam int CsrDataWidth = 20;
   localparam int CsrIndexWidth = 1;

   localparam logic [TimeoutWidth-1:0] TimeoutReset = TimeoutWidth'(500);
   localparam logic [ElapsedWidth-1:0] ElapsedMax   = {ElapsedWidth{1'b1}};
   localparam logic [CountWidth-1:0]   LastBit      = {CountWidth{1'b1}};

   typedef enum logic [1:0] {
      CMD_TICK  = 2'd0,
      CMD_RISE  = 2'd1,
      CMD_FALL  = 2'd2,
      CMD_WRITE = 2'd3
   } cmd_type;

   typedef enum logic [CsrIndexWidth-1:0] {
      CSR_TIMEOUT = 1'b0,
      CSR_IDLE    = 1'b1
   } csr_index_type;

   typedef struct packed {
      logic [TimeoutWidth-1:0] timeout_us;
      logic [ByteWidth-1:0]    idle_byte;
   } cfg_type;

   typedef struct packed {
      cmd_type              command;
      logic                 serial_in;
      logic [ByteWidth-1:0] tx_data;
   } req_item_type;

   typedef struct packed {
      logic                 serial_out;
      logic                 byte_done;
      logic [ByteWidth-1:0] rx_byte;
   } rsp_item_type;

   // handshake between the input register and the core
   typedef struct packed {
      logic         valid;
      req_item_type item;
   } stage_type;

endpackage

[hdl/cssu_channels.sv]
interface cssu_req_if;
   logic                           valid;
   logic                           ready;
   cssu_pkg::cmd_type              command;
   logic                           serial_in;
   logic [cssu_pkg::ByteWidth-1:0] tx_data;

   modport source (output valid, output command, output serial_in, output tx_data,
                   input ready);
   modport sink   (input valid, input command, input serial_in, input tx_data,
                   output ready);
endinterface

interface cssu_rsp_if;
   logic                           valid;
   logic                           ready;
   logic                           serial_out;
   logic                           byte_done;
   logic [cssu_pkg::ByteWidth-1:0] rx_byte;

   modport source (output valid, output serial_out, output byte_done, output rx_byte,
                   input ready);
   modport sink   (input valid, input serial_out, input byte_done, input rx_byte,
                   output ready);
endinterface

[hdl/cssu_csr_regs.sv]
module cssu_csr_regs (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 csr_write_enable,
   input  logic [cssu_pkg::CsrIndexWidth-1:0]   csr_index,
   input  logic [cssu_pkg::CsrDataWidth-1:0]    csr_write_data,
   output cssu_pkg::cfg_type                    cfg
);
   import cssu_pkg::*;

   cfg_type cfg_ff, cfg_in;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_write_enable) begin
         unique case (csr_index_type'(csr_index))
            CSR_TIMEOUT: cfg_in.timeout_us = csr_write_data[TimeoutWidth-1:0];
            CSR_IDLE:    cfg_in.idle_byte  = csr_write_data[ByteWidth-1:0];
            default:     cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.timeout_us <= TimeoutReset;
         cfg_ff.idle_byte  <= '0;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   assign cfg = cfg_ff;

endmodule

[hdl/cssu_in_stage.sv]
module cssu_in_stage (
   input  logic                clock,
   input  logic                reset,
   cssu_req_if.sink            req_ch,
   input  logic                take,
   output cssu_pkg::stage_type stage
);
   import cssu_pkg::*;

   logic         valid_ff, valid_in;
   req_item_type item_ff, item_in;
   logic         accept;

   assign req_ch.ready = !valid_ff || take;
   assign accept       = req_ch.valid && req_ch.ready;

   always_comb begin
      valid_in = valid_ff;
      item_in  = item_ff;
      if (accept) begin
         valid_in          = 1'b1;
         item_in.command   = req_ch.command;
         item_in.serial_in = req_ch.serial_in;
         item_in.tx_data   = req_ch.tx_data;
      end else if (take) begin
         valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      item_ff <= item_in;
   end

   assign stage.valid = valid_ff;
   assign stage.item  = item_ff;

endmodule

[hdl/cssu_core.sv]
module cssu_core (
   input  logic                clock,
   input  logic                reset,
   input  cssu_pkg::cfg_type   cfg,
   input  cssu_pkg::stage_type stage,
   output logic                take,
   cssu_rsp_if.source          rsp_ch
);
   import cssu_pkg::*;

   logic [ByteWidth-1:0]    rx_shift_ff, rx_shift_in;
   logic [CountWidth-1:0]   bit_count_ff, bit_count_in;
   logic [ByteWidth-1:0]    tx_shift_ff, tx_shift_in;
   logic [ByteWidth-1:0]    pending_byte_ff, pending_byte_in;
   logic                    pending_valid_ff, pending_valid_in;
   logic [ElapsedWidth-1:0] elapsed_ff, elapsed_in;
   logic                    out_level_ff, out_level_in;
   logic                    out_valid_ff, out_valid_in;
   rsp_item_type            rsp_ff, rsp_in;

   logic                    timed_out;
   logic [ByteWidth-1:0]    rx_base;
   logic [CountWidth-1:0]   count_base;

   // move the held item on when the result slot is free or being emptied
   assign take = stage.valid && (!out_valid_ff || rsp_ch.ready);

   assign timed_out  = elapsed_ff > {1'b0, cfg.timeout_us};
   assign rx_base    = timed_out ? '0 : rx_shift_ff;
   assign count_base = timed_out ? '0 : bit_count_ff;

   always_comb begin
      rx_shift_in      = rx_shift_ff;
      bit_count_in     = bit_count_ff;
      tx_shift_in      = tx_shift_ff;
      pending_byte_in  = pending_byte_ff;
      pending_valid_in = pending_valid_ff;
      elapsed_in       = elapsed_ff;
      out_level_in     = out_level_ff;
      rsp_in           = rsp_ff;
      out_valid_in     = out_valid_ff && !rsp_ch.ready;
      if (take) begin
         out_valid_in     = 1'b1;
         rsp_in.byte_done = 1'b0;
         rsp_in.rx_byte   = '0;
         unique case (stage.item.command)
            CMD_TICK: begin
               if (elapsed_ff != ElapsedMax) begin
                  elapsed_in = elapsed_ff + ElapsedWidth'(1);
               end
            end
            CMD_RISE: begin
               elapsed_in   = '0;
               rx_shift_in  = {rx_base[ByteWidth-2:0], stage.item.serial_in};
               bit_count_in = count_base + CountWidth'(1);
               if (count_base == LastBit) begin
                  // byte boundary: reload transmit from pending or idle
                  if (pending_valid_ff) begin
                     tx_shift_in      = pending_byte_ff;
                     pending_valid_in = 1'b0;
                  end else begin
                     tx_shift_in = cfg.idle_byte;
                  end
                  rsp_in.byte_done = 1'b1;
                  rsp_in.rx_byte   = rx_shift_in;
               end
            end
            CMD_FALL: begin
               out_level_in = tx_shift_ff[ByteWidth-1];
               tx_shift_in  = {tx_shift_ff[ByteWidth-2:0], 1'b0};
            end
            CMD_WRITE: begin
               if (bit_count_ff == '0) begin
                  tx_shift_in      = stage.item.tx_data;
                  pending_valid_in = 1'b0;
               end else begin
                  pending_byte_in  = stage.item.tx_data;
                  pending_valid_in = 1'b1;
               end
            end
            default: ;
         endcase
         rsp_in.serial_out = out_level_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rx_shift_ff      <= '0;
         bit_count_ff     <= '0;
         tx_shift_ff      <= '0;
         pending_byte_ff  <= '0;
         pending_valid_ff <= 1'b0;
         elapsed_ff       <= '0;
         out_level_ff     <= 1'b0;
         out_valid_ff     <= 1'b0;
      end else begin
         rx_shift_ff      <= rx_shift_in;
         bit_count_ff     <= bit_count_in;
         tx_shift_ff      <= tx_shift_in;
         pending_byte_ff  <= pending_byte_in;
         pending_valid_ff <= pending_valid_in;
         elapsed_ff       <= elapsed_in;
         out_level_ff     <= out_level_in;
         out_valid_ff     <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_ff <= rsp_in;
   end

   assign rsp_ch.valid      = out_valid_ff;
   assign rsp_ch.serial_out = rsp_ff.serial_out;
   assign rsp_ch.byte_done  = rsp_ff.byte_done;
   assign rsp_ch.rx_byte    = rsp_ff.rx_byte;

   a_take_fills_slot: assert property (@(posedge clock) disable iff (reset)
      take |=> out_valid_ff)
      else $error("result slot not filled after item taken");

   a_done_at_boundary: assert property (@(posedge clock) disable iff (reset)
      (take && stage.item.command == CMD_RISE) |=>
         (rsp_ff.byte_done == (bit_count_ff == '0)) && (elapsed_ff == '0))
      else $error("byte completion and bit count disagree");

   a_level_only_on_fall: assert property (@(posedge clock) disable iff (reset)
      !(take && stage.item.command == CMD_FALL) |=> $stable(out_level_ff))
      else $error("serial output moved without a falling edge");

   a_pending_cleared_idle: assert property (@(posedge clock) disable iff (reset)
      (take && stage.item.command == CMD_WRITE && bit_count_ff == '0)
         |=> !pending_valid_ff)
      else $error("pending byte kept after write between bytes");

endmodule

[hdl/clocked_serial_slave_shifter_unit.sv]
// Serial slave shifter, MSB first, driven by sampled clock edges and a
// microsecond tick delivered as items. Each item (tick, rising edge, falling
// edge or host write) yields exactly one result holding the current output
// level and, on the eighth rising edge, the received byte. One item is taken
// every clock cycle unless results stall; an item waits in the input
// register until the result slot is free or being emptied, the combinational
// state update computes its result, and the result register holds it. The
// user must write timeout and idle byte through the csr port only while no
// item is in flight; the block itself does not enforce it.
module clocked_serial_slave_shifter_unit (
   input  logic                               clock,
   input  logic                               reset,
   cssu_req_if.sink                           req_ch,
   cssu_rsp_if.source                         rsp_ch,
   input  logic                               csr_write_enable,
   input  logic [cssu_pkg::CsrIndexWidth-1:0] csr_index,
   input  logic [cssu_pkg::CsrDataWidth-1:0]  csr_write_data
);
   import cssu_pkg::*;

   cfg_type   cfg;
   stage_type stage;
   logic      take;

   cssu_csr_regs u_csr (
      .clock            (clock),
      .reset            (reset),
      .csr_write_enable (csr_write_enable),
      .csr_index        (csr_index),
      .csr_write_data   (csr_write_data),
      .cfg              (cfg)
   );

   cssu_in_stage u_in (
      .clock  (clock),
      .reset  (reset),
      .req_ch (req_ch),
      .take   (take),
      .stage  (stage)
   );

   cssu_core u_core (
      .clock  (clock),
      .reset  (reset),
      .cfg    (cfg),
      .stage  (stage),
      .take   (take),
      .rsp_ch (rsp_ch)
   );

endmodule

[tb/tb_clocked_serial_slave_shifter_unit.sv]
`timescale 1ns / 100ps

module tb_clocked_serial_slave_shifter_unit;
   import cssu_pkg::*;

   logic                       clock = 1'b0;
   logic                       reset;
   logic                       csr_write_enable;
   csr_index_type              csr_index;
   logic [CsrDataWidth-1:0]    csr_write_data;

   cssu_req_if req_ch();
   cssu_rsp_if rsp_ch();

   clocked_serial_slave_shifter_unit dut (
      .clock            (clock),
      .reset            (reset),
      .req_ch           (req_ch),
      .rsp_ch           (rsp_ch),
      .csr_write_enable (csr_write_enable),
      .csr_index        (csr_index),
      .csr_write_data   (csr_write_data)
   );

   // mirror of the shifter state and its settings
   logic [TimeoutWidth-1:0] cfg_timeout = TimeoutReset;
   logic [ByteWidth-1:0]    cfg_idle    = '0;
   logic [ByteWidth-1:0]    rx_acc      = '0;
   logic [CountWidth-1:0]   bit_pos     = '0;
   logic [ByteWidth-1:0]    tx_reg      = '0;
   logic [ByteWidth-1:0]    held_byte   = '0;
   logic                    held_valid  = 1'b0;
   logic [ElapsedWidth-1:0] quiet_us    = '0;
   logic                    line_level  = 1'b0;

   rsp_item_type expected_results[$];
   int unsigned  items_sent     = 0;
   int unsigned  mismatches     = 0;
   int unsigned  send_gap_pct   = 35;
   int unsigned  recv_stall_pct = 59;

   always begin
      #2 clock = 1'b1;
      #2 clock = 1'b0;
   end

   function automatic rsp_item_type shift_slave(req_item_type it);
      rsp_item_type r;
      r.byte_done = 1'b0;
      r.rx_byte   = '0;
      case (it.command)
         CMD_TICK: begin
            if (quiet_us != ElapsedMax) quiet_us = quiet_us + 1'b1;
         end
         CMD_RISE: begin
            // too long since the last edge: start the byte afresh
            if (quiet_us > ElapsedWidth'(cfg_timeout)) begin
               rx_acc  = '0;
               bit_pos = '0;
            end
            quiet_us = '0;
            rx_acc   = {rx_acc[ByteWidth-2:0], it.serial_in};
            if (bit_pos == LastBit) begin
               bit_pos = '0;
               tx_reg  = held_valid ? held_byte : cfg_idle;
               held_valid  = 1'b0;
               r.byte_done = 1'b1;
               r.rx_byte   = rx_acc;
            end else begin
               bit_pos = bit_pos + 1'b1;
            end
         end
         CMD_FALL: begin
            line_level = tx_reg[ByteWidth-1];
            tx_reg     = tx_reg << 1;
         end
         default: begin
            if (bit_pos == '0) begin
               tx_reg     = it.tx_data;
               held_valid = 1'b0;
            end else begin
               held_byte  = it.tx_data;
               held_valid = 1'b1;
            end
         end
      endcase
      r.serial_out = line_level;
      return r;
   endfunction

   function automatic void note_mismatch(string field, logic [7:0] want, logic [7:0] got);
      mismatches++;
      if (mismatches <= 100)
         $display("%0t: %s expected %h got %h", $time, field, want, got);
   endfunction

   always @(posedge clock) begin
      if (!reset && req_ch.valid && req_ch.ready)
         expected_results.push_back(shift_slave(
            req_item_type'{req_ch.command, req_ch.serial_in, req_ch.tx_data}));
   end

   always @(posedge clock) begin
      rsp_item_type want;
      if (!reset && rsp_ch.valid && rsp_ch.ready) begin
         if (expected_results.size() == 0) begin
            mismatches++;
            $display("%0t: unexpected item, expected none got %b %b %h", $time,
                     rsp_ch.serial_out, rsp_ch.byte_done, rsp_ch.rx_byte);
         end else begin
            want = expected_results.pop_front();
            if (rsp_ch.serial_out !== want.serial_out)
               note_mismatch("serial_out", 8'(want.serial_out), 8'(rsp_ch.serial_out));
            if (rsp_ch.byte_done !== want.byte_done)
               note_mismatch("byte_done", 8'(want.byte_done), 8'(rsp_ch.byte_done));
            if (rsp_ch.rx_byte !== want.rx_byte)
               note_mismatch("rx_byte", want.rx_byte, rsp_ch.rx_byte);
         end
      end
   end

   always @(posedge clock) rsp_ch.ready <= ($urandom_range(99) >= recv_stall_pct);

   task automatic send_item(cmd_type cmd, logic sin, logic [ByteWidth-1:0] data);
      while ($urandom_range(99) < send_gap_pct) begin
         req_ch.valid <= 1'b0;
         @(posedge clock);
      end
      req_ch.valid     <= 1'b1;
      req_ch.command   <= cmd;
      req_ch.serial_in <= sin;
      req_ch.tx_data   <= data;
      @(posedge clock);
      while (!req_ch.ready) @(posedge clock);
      items_sent++;
   endtask

   // drop valid and wait until every result is back
   task automatic settle();
      req_ch.valid <= 1'b0;
      @(posedge clock);
      while (expected_results.size() != 0) @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   task automatic write_csr(csr_index_type idx, logic [CsrDataWidth-1:0] data);
      settle();
      csr_write_enable <= 1'b1;
      csr_index        <= idx;
      csr_write_data   <= data;
      @(posedge clock);
      csr_write_enable <= 1'b0;
      if (idx == CSR_TIMEOUT) cfg_timeout = data;
      else cfg_idle = data[ByteWidth-1:0];
   endtask

   task automatic test_host_write_and_byte();
      send_item(CMD_FALL, 1'b1, 8'h00);
      send_item(CMD_WRITE, 1'b0, 8'hFF);
      send_item(CMD_FALL, 1'b0, 8'h00);
      for (int b = 0; b < 8; b++) begin
         send_item(CMD_RISE, 1'b1, 8'h00);
         send_item(CMD_FALL, 1'b0, 8'hFF);
         // park a byte mid-transfer, then overwrite it
         if (b == 2) send_item(CMD_WRITE, 1'b1, 8'h00);
         if (b == 4) send_item(CMD_WRITE, 1'b0, 8'h81);
      end
      send_item(CMD_FALL, 1'b0, 8'h00);
      send_item(CMD_WRITE, 1'b1, 8'h5A);
   endtask

   task automatic test_timeout_edges();
      write_csr(CSR_TIMEOUT, 20'd3);
      send_item(CMD_RISE, 1'b0, 8'h00);
      repeat (3) send_item(CMD_TICK, 1'b0, 8'h00);
      send_item(CMD_RISE, 1'b1, 8'h00);
      repeat (4) send_item(CMD_TICK, 1'b1, 8'hFF);
      send_item(CMD_RISE, 1'b1, 8'h00);
      write_csr(CSR_TIMEOUT, 20'd0);
      send_item(CMD_TICK, 1'b0, 8'h00);
      send_item(CMD_RISE, 1'b0, 8'h00);
   endtask

   task automatic test_random_traffic(int unsigned gap_pct, int unsigned stall_pct,
                                      logic [TimeoutWidth-1:0] timeout,
                                      logic [ByteWidth-1:0] idle, int unsigned count);
      int unsigned stop;
      int unsigned pick;
      int unsigned nbits;
      int unsigned gap;
      write_csr(CSR_TIMEOUT, timeout);
      write_csr(CSR_IDLE, {12'($urandom), idle});
      send_gap_pct   = gap_pct;
      recv_stall_pct = stall_pct;
      stop = items_sent + count;
      while (items_sent < stop) begin
         pick  = $urandom_range(99);
         nbits = (pick < 70) ? 8 : $urandom_range(1, 7);
         if (pick < 85) begin
            if ($urandom_range(1))
               send_item(CMD_WRITE, 1'($urandom_range(1)), 8'($urandom_range(255)));
            for (int b = 0; b < nbits; b++) begin
               send_item(CMD_FALL, 1'($urandom_range(1)), 8'($urandom_range(255)));
               gap = ($urandom_range(7) == 0) ? $urandom_range(1, 3) : 0;
               if ($urandom_range(31) == 0 && cfg_timeout < 64) gap = cfg_timeout + 1;
               repeat (gap)
                  send_item(CMD_TICK, 1'($urandom_range(1)), 8'($urandom_range(255)));
               send_item(CMD_RISE, 1'($urandom_range(1)), 8'($urandom_range(255)));
               if ($urandom_range(15) == 0)
                  send_item(CMD_WRITE, 1'($urandom_range(1)), 8'($urandom_range(255)));
            end
            // abandon a short byte: let the line go quiet past the timeout
            if (pick >= 70 && cfg_timeout < 64)
               repeat (cfg_timeout + 1 + $urandom_range(2))
                  send_item(CMD_TICK, 1'($urandom_range(1)), 8'($urandom_range(255)));
         end else begin
            repeat ($urandom_range(1, 5))
               send_item(cmd_type'($urandom_range(3)), 1'($urandom_range(1)),
                         8'($urandom_range(255)));
         end
      end
   endtask

   initial begin
      reset            = 1'b1;
      req_ch.valid     = 1'b0;
      req_ch.command   = CMD_TICK;
      req_ch.serial_in = 1'b0;
      req_ch.tx_data   = '0;
      csr_write_enable = 1'b0;
      csr_index        = CSR_TIMEOUT;
      csr_write_data   = '0;
      repeat (3) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      test_host_write_and_byte();
      test_timeout_edges();
      test_random_traffic(35, 59, 20'd12, 8'($urandom), 400);
      test_random_traffic(59, 35, 20'd0, 8'hFF, 400);
      test_random_traffic(0, 0, {TimeoutWidth{1'b1}}, 8'h00, 400);
      settle();

      if (mismatches == 0) begin
         $display("clocked_serial_slave_shifter_unit test passed");
      end else begin
         $display("clocked_serial_slave_shifter_unit test failed");
      end
      $finish;
   end

   initial begin
      #40_000_000;
      $display("clocked_serial_slave_shifter_unit test failed");
      $finish;
   end

endmodule
